/* hdl/mfde_pkg.sv */
// Package: shared constants, request codes and helper types for the draw engine.
`timescale 1ns / 1ps
`default_nettype none
package mfde_pkg;

    localparam int COLUMNS_DEF = 128;
    localparam int PAGES_DEF   = 8;
    localparam int SLOPE_SCALE = 10;

    typedef enum logic [2:0] {
        REQ_SET    = 3'd0,
        REQ_CLR    = 3'd1,
        REQ_LINE   = 3'd2,
        REQ_CIRCLE = 3'd3,
        REQ_CLRALL = 3'd4,
        REQ_READ   = 3'd5
    } req_t;

    // one plot command from the sequencer to the frame store
    typedef struct packed {
        logic       valid;
        logic       on;
        logic [7:0] col;
        logic [7:0] row;
    } plot_cmd_t;

endpackage
`default_nettype wire

/* hdl/mfde_req_if.sv */
// Interfaces: request and result channels with valid/ready handshake.
`timescale 1ns / 1ps
`default_nettype none
interface mfde_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] req_type;
    logic [7:0] x_a;
    logic [7:0] y_a;
    logic [7:0] x_b;
    logic [7:0] y_b;
    logic [7:0] radius;
    logic [2:0] read_page;
    modport source (output valid, req_type, x_a, y_a, x_b, y_b, radius, read_page,
                    input ready);
    modport sink (input valid, req_type, x_a, y_a, x_b, y_b, radius, read_page,
                  output ready);
endinterface

interface mfde_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    modport source (output valid, read_data, input ready);
    modport sink (input valid, read_data, output ready);
endinterface
`default_nettype wire

/* hdl/mfde_store.sv */
// Frame store: byte memory with read-modify-write plot path, clearing sweep and byte read.
`timescale 1ns / 1ps
`default_nettype none
module mfde_store #(
    parameter int COLUMNS = mfde_pkg::COLUMNS_DEF,
    parameter int PAGES   = mfde_pkg::PAGES_DEF
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire mfde_pkg::plot_cmd_t              cmd,
    input  wire                                   wipe,
    input  wire  [$clog2(COLUMNS*PAGES)-1:0]      wipe_addr,
    input  wire                                   rd,
    input  wire  [$clog2(COLUMNS*PAGES)-1:0]      rd_addr,
    output logic [7:0]                            rd_data,
    output logic                                  busy
);
    localparam int DEPTH = COLUMNS * PAGES;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int ROWS  = 8 * PAGES;

    logic [7:0] mem [DEPTH];

    // stage 1 registered command; stage 2 writes back
    logic            s1_valid_reg;
    logic            s1_on_reg;
    logic [AW-1:0]   s1_addr_reg;
    logic [2:0]      s1_bit_reg;
    logic [7:0]      s1_data_reg;
    logic            in_range;
    logic [AW-1:0]   cmd_addr;
    logic [PW-1:0]   cmd_page;
    logic [7:0]      wr_byte;

    assign in_range = cmd.valid && ({1'b0, cmd.col} < 9'(COLUMNS))
                      && ({1'b0, cmd.row} < 9'(ROWS));
    always_comb
    begin
        if (PAGES > 1)
            cmd_page = PW'(cmd.row >> 3);
        else
            cmd_page = '0;
    end
    assign cmd_addr = AW'(32'(cmd.col) * PAGES + 32'(cmd_page));
    assign busy = s1_valid_reg;

    // merged bit with forwarding from a write in the same cycle is not needed:
    // the sequencer stalls while busy, so reads always see committed data
    always_comb
    begin
        wr_byte = s1_data_reg;
        wr_byte[s1_bit_reg] = s1_on_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= in_range && !s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (wipe)
            mem[wipe_addr] <= 8'h00;
        else if (s1_valid_reg)
            mem[s1_addr_reg] <= wr_byte;
        s1_data_reg <= mem[cmd_addr];
        s1_addr_reg <= cmd_addr;
        s1_bit_reg  <= cmd.row[2:0];
        s1_on_reg   <= cmd.on;
        if (rd)
            rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

/* hdl/mono_framebuffer_draw_engine.sv */
// Top level: request sequencer with a shared step unit driving the frame store.
//
// Usage: one request word enters on req (valid/ready); exactly one result word
// leaves on rsp, carrying read_data (the frame byte for an in-range read, else
// zero). The block takes one request at a time; ready is low while it works.
// A plotted point inside the frame is a read then a write of its byte; a point
// outside it is not written. A sloped line first runs the slope divide, a
// circle plots eight points per step of its loop, and a clear-all sweeps all
// COLUMNS*PAGES bytes; a rejected line or unknown request goes straight to
// the result. The frame store's single write port paces every plot.
// After reset a clearing sweep runs; ready rises when the sweep ends. The
// result is held in an output register until the receiver takes it; a stalled
// receiver blocks the next request only, which can be accepted in the cycle
// after the result is taken.
`timescale 1ns / 1ps
`default_nettype none
module mono_framebuffer_draw_engine #(
    parameter int COLUMNS = mfde_pkg::COLUMNS_DEF,
    parameter int PAGES   = mfde_pkg::PAGES_DEF
) (
    input wire          clk,
    input wire          rst_n,
    mfde_req_if.sink    req,
    mfde_rsp_if.source  rsp
);
    localparam int DEPTH = COLUMNS * PAGES;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int ROWS  = 8 * PAGES;

    // job kinds held in kind_reg
    localparam logic [7:0] KIND_NONE      = 8'h00;
    localparam logic [7:0] KIND_VERT      = 8'h01;
    localparam logic [7:0] KIND_HORIZ     = 8'h02;
    localparam logic [7:0] KIND_DIAG      = 8'h03;
    localparam logic [7:0] KIND_CIRC_STEP = 8'hEE;
    localparam logic [7:0] KIND_WIPE_REQ  = 8'hFF;

    typedef enum logic [8:0] {
        ST_WIPE  = 9'b0_0000_0001,
        ST_IDLE  = 9'b0_0000_0010,
        ST_LINE  = 9'b0_0000_0100,
        ST_CIRC  = 9'b0_0000_1000,
        ST_CTEST = 9'b0_0001_0000,
        ST_PLOT  = 9'b0_0010_0000,
        ST_READ  = 9'b0_0100_0000,
        ST_DONE  = 9'b0_1000_0000,
        ST_DIV   = 9'b1_0000_0000
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [7:0]      xa_reg, ya_reg, rad_reg, xa_next, ya_next, rad_next;
    logic [7:0]      dx_reg, dx_next;
    logic [7:0]      k_reg, k_next;
    logic [7:0]      kind_reg, kind_next;
    logic [15:0]     acc_reg, acc_next;     // slope dividend, shifted out msb first
    logic [7:0]      drem_reg, drem_next;   // slope divide remainder
    logic [7:0]      quo_reg, quo_next;     // floor(i*k/10)
    logic [3:0]      rem_reg, rem_next;
    logic signed [19:0] ca_reg, cb_reg, ca_next, cb_next;
    logic [2:0]      oct_reg, oct_next;
    logic            on_reg, on_next;
    logic [7:0]      px_reg, py_reg, px_next, py_next;
    logic            pend_reg, pend_next;   // single pixel plot pending
    logic            rvalid_reg, rvalid_next;
    logic            zero_reg, zero_next;
    mfde_pkg::plot_cmd_t cmd;
    logic            wipe, st_busy, rd;
    logic [AW-1:0]   rd_addr;
    logic [7:0]      rd_data;
    logic [31:0]     rr;
    logic [31:0]     a_sq, b_sq;
    logic [31:0]     lhs;
    logic [7:0]      ua, ub;
    logic [8:0]      div_try;
    logic [15:0]     k_prod;
    logic [7:0]      k_tens;
    logic [3:0]      k_ones;

    mfde_store #(.COLUMNS(COLUMNS), .PAGES(PAGES)) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .wipe     (wipe),
        .wipe_addr(cnt_reg[AW-1:0]),
        .rd       (rd),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .busy     (st_busy)
    );

    assign req.ready     = (state_reg == ST_IDLE) && !rvalid_reg;
    assign rsp.valid     = rvalid_reg;
    assign rsp.read_data = zero_reg ? 8'h00 : rd_data;
    assign wipe          = (state_reg == ST_WIPE) && (cnt_reg < CW'(DEPTH));
    assign rd            = (state_reg == ST_READ);
    assign rd_addr       = AW'(32'(xa_reg) * PAGES + 32'(rad_reg));
    assign ua = ca_reg[7:0];
    assign ub = cb_reg[7:0];
    assign rr = 32'(rad_reg) * 32'(rad_reg);

    // circle test: b squared is shared by the loop test and the back-off test, a squared serves the back-off test
    assign a_sq = 32'(ca_reg * ca_reg);
    assign b_sq = 32'(cb_reg * cb_reg);
    assign lhs  = a_sq + b_sq;

    // slope divide: one restoring step per cycle
    assign div_try = {drem_reg, acc_reg[11]};

    // split k into tens and ones by reciprocal multiply (exact for 8 bits)
    assign k_prod = 16'(k_reg) * 16'd205;
    assign k_tens = 8'(k_prod >> 11);
    assign k_ones = 4'(k_reg - 8'(k_tens * 8'd10));

    // sequencer
    always_comb
    begin
        state_next = state_reg; cnt_next = cnt_reg;
        xa_next = xa_reg; ya_next = ya_reg; rad_next = rad_reg;
        dx_next = dx_reg; k_next = k_reg; kind_next = kind_reg;
        acc_next = acc_reg; drem_next = drem_reg;
        quo_next = quo_reg; rem_next = rem_reg;
        ca_next = ca_reg; cb_next = cb_reg; oct_next = oct_reg;
        on_next = on_reg; px_next = px_reg; py_next = py_reg;
        pend_next = pend_reg; rvalid_next = rvalid_reg; zero_next = zero_reg;
        cmd = '0;
        if (rvalid_reg && rsp.ready)
            rvalid_next = 1'b0;
        case (state_reg)
            ST_WIPE:
            begin
                if (cnt_reg >= CW'(DEPTH))
                    state_next = (kind_reg == KIND_WIPE_REQ) ? ST_DONE : ST_IDLE;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_IDLE:
            begin
                if (req.valid && req.ready)
                begin
                    xa_next = req.x_a; ya_next = req.y_a; rad_next = req.radius;
                    zero_next = 1'b1;
                    kind_next = KIND_NONE;
                    case (req.req_type)
                        mfde_pkg::REQ_SET, mfde_pkg::REQ_CLR:
                        begin
                            px_next = req.x_a; py_next = req.y_a;
                            on_next = (req.req_type == mfde_pkg::REQ_SET);
                            pend_next = 1'b1;
                            state_next = ST_PLOT;
                        end
                        mfde_pkg::REQ_LINE:
                        begin
                            if (req.x_b > 8'(COLUMNS) && COLUMNS < 256
                                || {1'b0, req.y_b} > 9'(ROWS)
                                || req.x_a > req.x_b || req.y_a > req.y_b)
                                state_next = ST_DONE;
                            else
                            begin
                                on_next = 1'b1;
                                cnt_next = '0;
                                quo_next = '0; rem_next = '0;
                                if (req.x_a == req.x_b)
                                begin
                                    kind_next = KIND_VERT;
                                    dx_next = req.y_b - req.y_a;
                                    state_next = ST_LINE;
                                end
                                else if (req.y_a == req.y_b)
                                begin
                                    kind_next = KIND_HORIZ;
                                    dx_next = req.x_b - req.x_a;
                                    state_next = ST_LINE;
                                end
                                else
                                begin
                                    // k = (dy*10)/dx, worked out in ST_DIV
                                    kind_next = KIND_DIAG;
                                    dx_next = req.x_b - req.x_a;
                                    acc_next = 16'(12'(req.y_b - req.y_a) * 12'd10);
                                    drem_next = '0;
                                    k_next = '0;
                                    state_next = ST_DIV;
                                end
                            end
                        end
                        mfde_pkg::REQ_CIRCLE:
                        begin
                            on_next = 1'b1;
                            if (req.radius == 8'd0)
                            begin
                                px_next = req.x_a; py_next = req.y_a;
                                pend_next = 1'b1;
                                state_next = ST_PLOT;
                            end
                            else
                            begin
                                ca_next = '0; cb_next = 20'(req.radius);
                                state_next = ST_CTEST;
                            end
                        end
                        mfde_pkg::REQ_CLRALL:
                        begin
                            cnt_next = '0; kind_next = KIND_WIPE_REQ;
                            state_next = ST_WIPE;
                        end
                        mfde_pkg::REQ_READ:
                        begin
                            if ({1'b0, req.x_a} < 9'(COLUMNS)
                                && 6'(req.read_page) < 6'(PAGES))
                            begin
                                zero_next = 1'b0;
                                rad_next = 8'(req.read_page);
                            end
                            state_next = ST_READ;
                        end
                        default: state_next = ST_DONE;
                    endcase
                end
            end
            ST_DIV:
            begin
                // 12 quotient bits, only the low 8 are kept in k
                if (div_try >= {1'b0, dx_reg})
                begin
                    drem_next = 8'(div_try - {1'b0, dx_reg});
                    k_next = {k_reg[6:0], 1'b1};
                end
                else
                begin
                    drem_next = div_try[7:0];
                    k_next = {k_reg[6:0], 1'b0};
                end
                acc_next = acc_reg << 1;
                if (cnt_reg == CW'(11))
                begin
                    cnt_next = '0;
                    state_next = ST_LINE;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_READ: state_next = ST_DONE;
            ST_PLOT:
            begin
                if (!st_busy)
                begin
                    cmd.valid = pend_reg; cmd.on = on_reg;
                    cmd.col = px_reg; cmd.row = py_reg;
                    pend_next = 1'b0;
                    state_next = ST_DONE;
                end
            end
            ST_LINE:
            begin
                if (!st_busy)
                begin
                    if (cnt_reg >= CW'(dx_reg))
                        state_next = ST_DONE;
                    else
                    begin
                        cmd.valid = 1'b1; cmd.on = 1'b1;
                        case (kind_reg)
                            KIND_VERT:
                            begin
                                cmd.col = xa_reg; cmd.row = ya_reg + 8'(cnt_reg);
                            end
                            KIND_HORIZ:
                            begin
                                cmd.col = xa_reg + 8'(cnt_reg); cmd.row = ya_reg;
                            end
                            default:
                            begin
                                cmd.col = xa_reg + 8'(cnt_reg);
                                cmd.row = ya_reg + quo_reg;
                            end
                        endcase
                        cnt_next = cnt_reg + 1'b1;
                        // step floor(i*k/10): add k, carry tens by compare
                        if (5'(rem_reg) + 5'(k_ones) >= 5'd10)
                        begin
                            rem_next = 4'(5'(rem_reg) + 5'(k_ones) - 5'd10);
                            quo_next = quo_reg + k_tens + 8'd1;
                        end
                        else
                        begin
                            rem_next = 4'(5'(rem_reg) + 5'(k_ones));
                            quo_next = quo_reg + k_tens;
                        end
                    end
                end
            end
            ST_CTEST:
            begin
                if ((b_sq << 1) >= rr)
                begin
                    oct_next = '0;
                    state_next = ST_CIRC;
                end
                else
                    state_next = ST_DONE;
            end
            ST_CIRC:
            begin
                if (!st_busy)
                begin
                    cmd.valid = 1'b1; cmd.on = 1'b1;
                    case (oct_reg)
                        3'd0: begin cmd.col = xa_reg + ua; cmd.row = ya_reg - ub; end
                        3'd1: begin cmd.col = xa_reg - ua; cmd.row = ya_reg - ub; end
                        3'd2: begin cmd.col = xa_reg - ua; cmd.row = ya_reg + ub; end
                        3'd3: begin cmd.col = xa_reg + ua; cmd.row = ya_reg + ub; end
                        3'd4: begin cmd.col = xa_reg + ub; cmd.row = ya_reg + ua; end
                        3'd5: begin cmd.col = xa_reg + ub; cmd.row = ya_reg - ua; end
                        3'd6: begin cmd.col = xa_reg - ub; cmd.row = ya_reg - ua; end
                        default: begin cmd.col = xa_reg - ub; cmd.row = ya_reg + ua; end
                    endcase
                    oct_next = oct_reg + 3'd1;
                    if (oct_reg == 3'd7)
                    begin
                        ca_next = ca_reg + 20'sd1;
                        state_next = ST_DONE;
                        kind_next = KIND_CIRC_STEP;
                    end
                end
            end
            ST_DONE:
            begin
                if (kind_reg == KIND_CIRC_STEP)
                begin
                    // circle back-off step
                    kind_next = KIND_NONE;
                    if (lhs > rr)
                    begin
                        ca_next = ca_reg - 20'sd1;
                        cb_next = cb_reg - 20'sd1;
                    end
                    state_next = ST_CTEST;
                end
                else if (!st_busy && !rvalid_reg)
                begin
                    rvalid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_WIPE;
            cnt_reg    <= '0;
            rvalid_reg <= 1'b0;
            kind_reg   <= KIND_NONE;
            pend_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            rvalid_reg <= rvalid_next;
            kind_reg   <= kind_next;
            pend_reg   <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        xa_reg <= xa_next; ya_reg <= ya_next; rad_reg <= rad_next;
        dx_reg <= dx_next; k_reg <= k_next;
        acc_reg <= acc_next; drem_reg <= drem_next;
        quo_reg <= quo_next; rem_reg <= rem_next;
        ca_reg <= ca_next; cb_reg <= cb_next; oct_reg <= oct_next;
        on_reg <= on_next; px_reg <= px_next; py_reg <= py_next;
        zero_reg <= zero_next;
    end
endmodule
`default_nettype wire
